### rtl/gin_pkg.sv
// Shared types and constants of the greedy IoU non-maximum suppression unit.
package gin_pkg;

    localparam int MAX_BOXES   = 64;
    localparam int IDX_W       = $clog2(MAX_BOXES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IOU_NUM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IOU_DEN = 1'd1;

    localparam logic [7:0] IOU_NUM_RESET = 8'd3;
    localparam logic [7:0] IOU_DEN_RESET = 8'd10;

    typedef struct packed {
        logic [11:0]        x;
        logic [11:0]        y;
        logic [7:0]         w;
        logic [7:0]         h;
        logic signed [15:0] score;
        logic [7:0]         tag;
    } box_t;

    typedef struct packed {
        box_t box;
        logic last;
    } item_t;

    typedef struct packed {
        box_t box;
        logic last;
        logic overflowed;
    } result_t;

    typedef struct packed {
        logic [7:0] num;
        logic [7:0] den;
    } thresh_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FETCH,
        ST_FWAIT,
        ST_EMIT
    } eng_state_t;

endpackage

### rtl/greedy_iou_nms_unit.sv
// Top level of the greedy IoU non-maximum suppression unit.
// Loading: the input queue takes a box every cycle that it is not full while the engine loads.
// Run: one sweep over the N stored boxes, then per kept box a fetch, a sweep and an emit;
// the emit waits while the result queue is full.
// Each sweep reads the stored boxes through the single-read-port box store.
// Reset clears queues, counts and flags and sets the IoU threshold to 3/10.
module greedy_iou_nms_unit
    import gin_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [11:0]          box_x,
    input  logic [11:0]          box_y,
    input  logic [7:0]           box_w,
    input  logic [7:0]           box_h,
    input  logic signed [15:0]   box_score,
    input  logic [7:0]           box_tag,
    input  logic                 in_last,
    output logic                 empty,
    input  logic                 pop,
    output logic [11:0]          kept_x,
    output logic [11:0]          kept_y,
    output logic [7:0]           kept_w,
    output logic [7:0]           kept_h,
    output logic signed [15:0]   kept_score,
    output logic [7:0]           kept_tag,
    output logic                 out_last,
    output logic                 overflowed,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    thresh_t thresh_reg;
    item_t   in_item;
    item_t   q_item;
    logic    q_valid;
    logic    q_ready;
    logic    res_push;
    logic    res_full;
    result_t res_data;
    result_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.num <= IOU_NUM_RESET;
            thresh_reg.den <= IOU_DEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IOU_NUM: thresh_reg.num <= cfg_data;
                REG_IOU_DEN: thresh_reg.den <= cfg_data;
                default:     thresh_reg     <= thresh_reg;
            endcase
        end
    end

    assign in_item.box.x     = box_x;
    assign in_item.box.y     = box_y;
    assign in_item.box.w     = box_w;
    assign in_item.box.h     = box_h;
    assign in_item.box.score = box_score;
    assign in_item.box.tag   = box_tag;
    assign in_item.last      = in_last;

    gin_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    gin_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .thresh   (thresh_reg),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .res_push (res_push),
        .res_full (res_full),
        .res_data (res_data)
    );

    gin_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_full (res_full),
        .wr_data (res_data),
        .empty   (empty),
        .pop     (pop),
        .rd_data (head)
    );

    assign kept_x     = head.box.x;
    assign kept_y     = head.box.y;
    assign kept_w     = head.box.w;
    assign kept_h     = head.box.h;
    assign kept_score = head.box.score;
    assign kept_tag   = head.box.tag;
    assign out_last   = head.last;
    assign overflowed = head.overflowed;

endmodule

### rtl/gin_front.sv
// Input queue: takes boxes from the push side and hands them to the engine.
module gin_front
    import gin_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_wr;
    logic        do_rd;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/gin_out_queue.sv
// Result queue: holds kept boxes until the pop side takes them.
module gin_out_queue
    import gin_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    output logic    wr_full,
    input  result_t wr_data,
    output logic    empty,
    input  logic    pop,
    output result_t rd_data
);

    result_t     mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_wr;
    logic        do_rd;

    assign wr_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !wr_full;
    assign do_rd   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/gin_engine.sv
// Suppression engine: box store, best-box search and pairwise IoU suppression.
module gin_engine
    import gin_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  thresh_t thresh,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    res_push,
    input  logic    res_full,
    output result_t res_data
);

    box_t                box_mem [MAX_BOXES];
    box_t                rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;

    eng_state_t          state_reg;
    eng_state_t          state_next;

    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [MAX_BOXES-1:0] removed_reg;
    logic [CNT_W-1:0]    issue_idx_reg;
    logic                issuing;
    logic                scan_done;
    logic                load_acc;
    logic                emit_acc;

    logic                s1_valid_reg;
    logic [IDX_W-1:0]    s1_idx_reg;

    logic                s2_valid_reg;
    logic [IDX_W-1:0]    s2_idx_reg;
    logic [7:0]          s2_dx_reg;
    logic [7:0]          s2_dy_reg;
    logic                s2_ov_reg;
    logic [15:0]         s2_area_reg;
    logic signed [15:0]  s2_score_reg;

    logic                s3_valid_reg;
    logic [IDX_W-1:0]    s3_idx_reg;
    logic [15:0]         s3_inter_reg;
    logic [16:0]         s3_uni_reg;
    logic                s3_ov_reg;
    logic signed [15:0]  s3_score_reg;

    logic                best_found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic signed [15:0]  best_score_reg;

    box_t                a_reg;
    logic [15:0]         area_a_reg;
    logic                have_a_reg;

    logic [12:0]         ax2;
    logic [12:0]         bx2;
    logic [12:0]         ay2;
    logic [12:0]         by2;
    logic [12:0]         x1;
    logic [12:0]         y1;
    logic [12:0]         x2;
    logic [12:0]         y2;
    logic [15:0]         inter;
    logic [23:0]         lhs;
    logic [24:0]         rhs;
    logic                s3_live;
    logic                supp;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && in_item.last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = have_a_reg ? ST_EMIT : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                state_next = ST_SCAN;
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = best_found_reg ? ST_FETCH : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        res_push = 1'b0;
        issuing  = 1'b0;
        rd_addr  = best_idx_reg;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                issuing = (issue_idx_reg < count_reg);
                rd_addr = issue_idx_reg[IDX_W-1:0];
            end
            ST_EMIT:
            begin
                res_push = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign scan_done = !issuing && !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign load_acc  = in_valid && in_ready;
    assign emit_acc  = res_push && !res_full;

    assign res_data.box        = a_reg;
    assign res_data.last       = !best_found_reg;
    assign res_data.overflowed = ovf_reg;

    // stage 2 geometry
    assign ax2 = {1'b0, a_reg.x} + {5'b0, a_reg.w};
    assign bx2 = {1'b0, rd_data_reg.x} + {5'b0, rd_data_reg.w};
    assign ay2 = {1'b0, a_reg.y} + {5'b0, a_reg.h};
    assign by2 = {1'b0, rd_data_reg.y} + {5'b0, rd_data_reg.h};
    assign x1  = (a_reg.x > rd_data_reg.x) ? {1'b0, a_reg.x} : {1'b0, rd_data_reg.x};
    assign y1  = (a_reg.y > rd_data_reg.y) ? {1'b0, a_reg.y} : {1'b0, rd_data_reg.y};
    assign x2  = (ax2 < bx2) ? ax2 : bx2;
    assign y2  = (ay2 < by2) ? ay2 : by2;

    // stage 4 decision
    assign lhs     = s3_inter_reg * thresh.den;
    assign rhs     = s3_uni_reg * thresh.num;
    assign s3_live = s3_valid_reg && !removed_reg[s3_idx_reg];
    assign supp    = have_a_reg && s3_ov_reg && ({1'b0, lhs} > rhs);
    assign inter   = s2_dx_reg * s2_dy_reg;

    always_ff @(posedge clk)
    begin
        if (load_acc && (count_reg < CNT_W'(MAX_BOXES)))
        begin
            box_mem[count_reg[IDX_W-1:0]] <= in_item.box;
        end
        rd_data_reg <= box_mem[rd_addr];

        s1_idx_reg   <= issue_idx_reg[IDX_W-1:0];

        s2_idx_reg   <= s1_idx_reg;
        s2_dx_reg    <= 8'(x2 - x1);
        s2_dy_reg    <= 8'(y2 - y1);
        s2_ov_reg    <= (x2 > x1) && (y2 > y1);
        s2_area_reg  <= rd_data_reg.w * rd_data_reg.h;
        s2_score_reg <= rd_data_reg.score;

        s3_idx_reg   <= s2_idx_reg;
        s3_inter_reg <= inter;
        s3_uni_reg   <= {1'b0, area_a_reg} + {1'b0, s2_area_reg} - {1'b0, inter};
        s3_ov_reg    <= s2_ov_reg;
        s3_score_reg <= s2_score_reg;

        if (state_reg == ST_FWAIT)
        begin
            a_reg      <= rd_data_reg;
            area_a_reg <= rd_data_reg.w * rd_data_reg.h;
        end
        if (s3_live && !supp && (!best_found_reg || (s3_score_reg > best_score_reg)))
        begin
            best_idx_reg   <= s3_idx_reg;
            best_score_reg <= s3_score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            removed_reg    <= '0;
            issue_idx_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            have_a_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issuing;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;

            if (load_acc)
            begin
                if (count_reg < CNT_W'(MAX_BOXES))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (issuing)
            begin
                issue_idx_reg <= issue_idx_reg + CNT_W'(1);
            end

            // restart the sweep
            if ((state_next == ST_SCAN) && (state_reg != ST_SCAN))
            begin
                issue_idx_reg  <= '0;
                best_found_reg <= 1'b0;
            end

            if (s3_live)
            begin
                if (supp)
                begin
                    removed_reg[s3_idx_reg] <= 1'b1;
                end
                else
                begin
                    best_found_reg <= 1'b1;
                end
            end

            if (state_reg == ST_FWAIT)
            begin
                removed_reg[best_idx_reg] <= 1'b1;
                have_a_reg                <= 1'b1;
            end

            if (emit_acc && !best_found_reg)
            begin
                count_reg   <= '0;
                ovf_reg     <= 1'b0;
                removed_reg <= '0;
                have_a_reg  <= 1'b0;
            end
        end
    end

endmodule
